// ----- rtl/ccbm_pkg.sv -----
// shared types, codes and constants of the console bus decoder and bank mapper
`default_nettype none

package ccbm_pkg;

    // field widths
    localparam int KIND_W     = 3;
    localparam int ADDR_W     = 16;
    localparam int DATA_W     = 8;
    localparam int SLOT_W     = 3;
    localparam int BANK_W     = 8;
    localparam int TARGET_W   = 4;
    localparam int EXT_W      = 21;
    localparam int CNT_W      = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    typedef logic [KIND_W-1:0]   t_kind;
    typedef logic [ADDR_W-1:0]   t_addr;
    typedef logic [DATA_W-1:0]   t_data;
    typedef logic [SLOT_W-1:0]   t_slot;
    typedef logic [BANK_W-1:0]   t_bank;
    typedef logic [TARGET_W-1:0] t_target;
    typedef logic [EXT_W-1:0]    t_ext;
    typedef logic [CNT_W-1:0]    t_cnt;

    // item kinds
    localparam t_kind KIND_CPU_RD      = 3'd0;
    localparam t_kind KIND_CPU_WR      = 3'd1;
    localparam t_kind KIND_CHR_RD      = 3'd2;
    localparam t_kind KIND_CHR_WR      = 3'd3;
    localparam t_kind KIND_MAP_PRG     = 3'd4;
    localparam t_kind KIND_MAP_CHR_ROM = 3'd5;
    localparam t_kind KIND_MAP_CHR_RAM = 3'd6;
    localparam t_kind KIND_REINIT      = 3'd7;

    // result targets
    localparam t_target TGT_RAM      = 4'd0;
    localparam t_target TGT_IO       = 4'd1;
    localparam t_target TGT_NONE     = 4'd2;
    localparam t_target TGT_SRAM     = 4'd3;
    localparam t_target TGT_PRG_ROM  = 4'd4;
    localparam t_target TGT_MAPPER   = 4'd5;
    localparam t_target TGT_CHR_ROM  = 4'd6;
    localparam t_target TGT_CHR_RAM  = 4'd7;
    localparam t_target TGT_MAP_DONE = 4'd8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PRG_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHR_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SRAM_EN   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAPPER    = 2'd3;

    // configuration reset values
    localparam t_cnt RST_PRG_COUNT = 9'd4;
    localparam t_cnt RST_CHR_COUNT = 9'd8;

    // bus map boundaries
    localparam t_addr ADR_IO_LO  = 16'h2000;
    localparam t_addr ADR_IO_END = 16'h4020;
    localparam t_addr ADR_SRAM   = 16'h6000;
    localparam t_addr ADR_PRG    = 16'h8000;

    // bank limits
    localparam t_cnt MAX_PRG_BANKS = 9'd256;
    localparam t_cnt MAX_CHR_BANKS = 9'd256;
    localparam t_cnt CHR_RAM_BANKS = 9'd8;

    // window map memory: program windows at 0-3, pattern windows at 8-15
    localparam int PRG_WINDOWS = 4;
    localparam int CHR_WINDOWS = 8;
    localparam int MAP_DEPTH   = 16;
    localparam int MAP_AW      = 4;
    localparam int WIN_W       = 4;
    typedef logic [MAP_AW-1:0] t_map_addr;
    typedef logic [WIN_W-1:0]  t_win;
    localparam t_win LAST_WINDOW = t_win'(PRG_WINDOWS + CHR_WINDOWS - 1);

    // remainder unit
    localparam int DIV_BITS_PER_CYCLE = 2;
    localparam int DIV_STEPS          = BANK_W / DIV_BITS_PER_CYCLE;
    localparam int DIV_STEP_W         = $clog2(DIV_STEPS);

    typedef struct packed {
        logic  start;
        t_bank dividend;
        t_cnt  divisor;
    } t_div_req;

    typedef struct packed {
        logic  done;
        t_bank rem;
    } t_div_rsp;

    // one result word
    typedef struct packed {
        t_target target;
        t_ext    ext_addr;
        t_data   read_data;
        t_data   write_data;
        logic    is_write;
    } t_rsp;

endpackage

`default_nettype wire

// ----- rtl/ccbm_if.sv -----
// request and result channel interfaces of the bus decoder
`default_nettype none

interface ccbm_req_if;
    logic            valid;
    logic            ready;
    ccbm_pkg::t_kind kind;
    ccbm_pkg::t_addr address;
    ccbm_pkg::t_data data;
    ccbm_pkg::t_slot slot;
    ccbm_pkg::t_bank bank;

    modport source (output valid, kind, address, data, slot, bank, input ready);
    modport sink   (input valid, kind, address, data, slot, bank, output ready);
endinterface

interface ccbm_rsp_if;
    logic              valid;
    logic              ready;
    ccbm_pkg::t_target target;
    ccbm_pkg::t_ext    ext_addr;
    ccbm_pkg::t_data   read_data;
    ccbm_pkg::t_data   write_data;
    logic              is_write;

    modport source (output valid, target, ext_addr, read_data, write_data, is_write,
                    input ready);
    modport sink   (input valid, target, ext_addr, read_data, write_data, is_write,
                    output ready);
endinterface

`default_nettype wire

// ----- rtl/ccbm_ram.sv -----
// generic simple dual-port ram with registered read
`default_nettype none

module ccbm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire                       i_clk,
    input  wire                       i_we,
    input  wire  [$clog2(DEPTH)-1:0]  i_waddr,
    input  wire  [WIDTH-1:0]          i_wdata,
    input  wire                       i_re,
    input  wire  [$clog2(DEPTH)-1:0]  i_raddr,
    output logic [WIDTH-1:0]          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- rtl/ccbm_mod_unit.sv -----
// iterative remainder unit for bank reduction, two quotient bits per cycle
`default_nettype none

module ccbm_mod_unit (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire ccbm_pkg::t_div_req i_req,
    output ccbm_pkg::t_div_rsp      o_rsp
);

    logic                                r_busy;
    logic                                r_done;
    logic [ccbm_pkg::DIV_STEP_W-1:0]     r_step;
    ccbm_pkg::t_cnt                      r_rem;
    ccbm_pkg::t_bank                     r_dvd;
    ccbm_pkg::t_cnt                      r_dsr;
    ccbm_pkg::t_cnt                      n_rem;

    // one restoring step: shift in a dividend bit, subtract when it fits
    function automatic ccbm_pkg::t_cnt rem_step(ccbm_pkg::t_cnt rem, logic din,
                                                ccbm_pkg::t_cnt dsr);
        logic [ccbm_pkg::CNT_W:0] t;
        t = {rem, din};
        if (t >= {1'b0, dsr}) begin
            t = t - {1'b0, dsr};
        end
        return t[ccbm_pkg::CNT_W-1:0];
    endfunction

    // the steps of one cycle
    always_comb begin
        n_rem = r_rem;
        for (int k = 0; k < ccbm_pkg::DIV_BITS_PER_CYCLE; k++) begin
            n_rem = rem_step(n_rem, r_dvd[ccbm_pkg::BANK_W-1-k], r_dsr);
        end
    end

    // iteration control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= '0;
                r_rem  <= '0;
                r_dvd  <= i_req.dividend;
                r_dsr  <= i_req.divisor;
            end else if (r_busy) begin
                r_rem  <= n_rem;
                r_dvd  <= r_dvd << ccbm_pkg::DIV_BITS_PER_CYCLE;
                r_step <= r_step + 1'b1;
                if (r_step == ccbm_pkg::DIV_STEP_W'(ccbm_pkg::DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem[ccbm_pkg::BANK_W-1:0];

endmodule

`default_nettype wire

// ----- rtl/console_cpu_bus_bank_mapper_top.sv -----
// bus decoder and bank mapper for an 8-bit console cpu and pattern bus
//
// i_req carries one access or map word per handshake (valid and ready high
// at a rising edge); o_rsp returns exactly one result word for each, in order.
// access words (cpu and pattern reads and writes): the work ram
// and the window map memory are read in the accept cycle, the result is
// formed and registered in the next once the output register is free; a new
// word is accepted only after the sequencer is back in idle. map words run
// the bank number through the remainder unit. a reinit word recomputes all
// twelve windows.
// the result sits in an output register; the next word is accepted while it
// waits, and a stalled receiver holds the block only when a second result is
// ready to be written.
// after reset the block clears the work ram, one byte a cycle, then loads
// the reset window banks; i_req.ready stays low meanwhile, configuration
// writes are taken at any time.
// configuration: i_cfg_we writes i_cfg_data to register i_cfg_idx
// (0 program bank count, 1 pattern bank count, 2 save ram enable,
// 3 mapper present); write only while the block is idle.
`default_nettype none

module console_cpu_bus_bank_mapper_top #(
    parameter int RAM_BYTES = 2048
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_cfg_we,
    input  wire  [ccbm_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire  [ccbm_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    ccbm_req_if.sink                            i_req,
    ccbm_rsp_if.source                          o_rsp
);

    localparam int AW = $clog2(RAM_BYTES);

    // sequencer states
    localparam logic [2:0] S_CLEAR     = 3'd0;
    localparam logic [2:0] S_IDLE      = 3'd1;
    localparam logic [2:0] S_EXEC      = 3'd2;
    localparam logic [2:0] S_DIV       = 3'd3;
    localparam logic [2:0] S_INIT      = 3'd4;
    localparam logic [2:0] S_INIT_WAIT = 3'd5;
    localparam logic [2:0] S_FINISH    = 3'd6;

    logic [2:0]          r_state;
    logic [2:0]          n_state;
    logic [AW-1:0]       r_clr_addr;
    ccbm_pkg::t_win      r_win;
    logic                r_init_rsp;

    ccbm_pkg::t_cnt      r_prg_cnt;
    ccbm_pkg::t_cnt      r_chr_cnt;
    logic                r_sram_en;
    logic                r_mapper_en;
    logic                r_chr_ram;

    ccbm_pkg::t_kind     r_kind;
    ccbm_pkg::t_addr     r_adr;
    ccbm_pkg::t_data     r_dat;
    ccbm_pkg::t_slot     r_slot;
    ccbm_pkg::t_bank     r_bank;

    logic                r_out_valid;
    ccbm_pkg::t_rsp      r_out;

    logic                w_acc;
    logic                w_out_free;
    logic                w_is_map;
    ccbm_pkg::t_cnt      w_prg_eff;
    ccbm_pkg::t_cnt      w_chr_eff;
    logic                w_chr_present;
    ccbm_pkg::t_cnt      w_init_prg_cnt;
    ccbm_pkg::t_cnt      w_init_chr_cnt;

    logic                w_ram_we;
    logic [AW-1:0]       w_ram_waddr;
    ccbm_pkg::t_data     w_ram_wdata;
    ccbm_pkg::t_data     w_ram_rd;

    logic                w_map_we;
    ccbm_pkg::t_map_addr w_map_waddr;
    ccbm_pkg::t_map_addr w_map_raddr;
    ccbm_pkg::t_bank     w_map_rd;
    logic                w_item_map_en;
    ccbm_pkg::t_map_addr w_item_map_addr;

    logic                w_win_chr;
    ccbm_pkg::t_slot     w_win_idx;

    ccbm_pkg::t_div_req  w_div_req;
    ccbm_pkg::t_div_rsp  w_div_rsp;
    ccbm_pkg::t_rsp      w_res;
    ccbm_pkg::t_rsp      w_map_done;

    // zero counts act as one, large counts clamp to the maximum
    function automatic ccbm_pkg::t_cnt eff_count(ccbm_pkg::t_cnt c, ccbm_pkg::t_cnt lim);
        ccbm_pkg::t_cnt e;
        e = c;
        if (c == '0) begin
            e = ccbm_pkg::t_cnt'(1);
        end else if (c > lim) begin
            e = lim;
        end
        return e;
    endfunction

    assign w_prg_eff     = eff_count(r_prg_cnt, ccbm_pkg::MAX_PRG_BANKS);
    assign w_chr_eff     = eff_count(r_chr_cnt, ccbm_pkg::MAX_CHR_BANKS);
    assign w_chr_present = (r_chr_cnt != '0);

    // the window setup after reset follows the reset bank counts
    assign w_init_prg_cnt = r_init_rsp ? r_prg_cnt : ccbm_pkg::RST_PRG_COUNT;
    assign w_init_chr_cnt = r_init_rsp ? r_chr_cnt : ccbm_pkg::RST_CHR_COUNT;

    // handshakes
    assign i_req.ready = (r_state == S_IDLE);
    assign w_acc       = i_req.valid && i_req.ready;
    assign w_out_free  = !r_out_valid || o_rsp.ready;
    assign w_is_map    = (r_kind >= ccbm_pkg::KIND_MAP_PRG);

    // work ram: clearing sweep after reset, cpu writes on completion
    assign w_ram_we = (r_state == S_CLEAR) ||
                      ((r_state == S_EXEC) && w_out_free &&
                       (r_kind == ccbm_pkg::KIND_CPU_WR) && (r_adr < ccbm_pkg::ADR_IO_LO));
    assign w_ram_waddr = (r_state == S_CLEAR) ? r_clr_addr : r_adr[AW-1:0];
    assign w_ram_wdata = (r_state == S_CLEAR) ? '0 : r_dat;

    ccbm_ram #(
        .WIDTH (ccbm_pkg::DATA_W),
        .DEPTH (RAM_BYTES)
    ) u_work_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_acc),
        .i_raddr (i_req.address[AW-1:0]),
        .o_rdata (w_ram_rd)
    );

    // window being set up during a window sweep, after reset or on a reinit word
    assign w_win_chr = (r_win >= ccbm_pkg::t_win'(ccbm_pkg::PRG_WINDOWS));
    assign w_win_idx = w_win_chr ? (r_win[ccbm_pkg::SLOT_W-1:0] - 3'd4)
                                 : r_win[ccbm_pkg::SLOT_W-1:0];

    // window map memory read address from the incoming word
    always_comb begin
        if ((i_req.kind == ccbm_pkg::KIND_CHR_RD) || (i_req.kind == ccbm_pkg::KIND_CHR_WR)) begin
            w_map_raddr = {1'b1, i_req.address[12:10]};
        end else begin
            w_map_raddr = {2'b00, i_req.address[14:13]};
        end
    end

    // map word write target and whether it takes effect
    always_comb begin
        w_item_map_addr = {1'b1, r_slot};
        w_item_map_en   = 1'b0;
        unique case (r_kind) inside
            ccbm_pkg::KIND_MAP_PRG: begin
                w_item_map_addr = {1'b0, r_slot};
                w_item_map_en   = !r_slot[ccbm_pkg::SLOT_W-1];
            end
            ccbm_pkg::KIND_MAP_CHR_ROM: begin
                w_item_map_en = w_chr_present;
            end
            ccbm_pkg::KIND_MAP_CHR_RAM: begin
                w_item_map_en = 1'b1;
            end
            default: begin
                w_item_map_en = 1'b0;
            end
        endcase
    end

    assign w_map_we = w_div_rsp.done &&
                      (((r_state == S_DIV) && w_item_map_en) || (r_state == S_INIT_WAIT));
    assign w_map_waddr = (r_state == S_INIT_WAIT) ? {w_win_chr, w_win_idx} : w_item_map_addr;

    ccbm_ram #(
        .WIDTH (ccbm_pkg::BANK_W),
        .DEPTH (ccbm_pkg::MAP_DEPTH)
    ) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (w_map_we),
        .i_waddr (w_map_waddr),
        .i_wdata (w_div_rsp.rem),
        .i_re    (w_acc),
        .i_raddr (w_map_raddr),
        .o_rdata (w_map_rd)
    );

    // remainder requests from map words and from the window sweeps after reset and on reinit
    always_comb begin
        w_div_req.start    = 1'b0;
        w_div_req.dividend = r_bank;
        w_div_req.divisor  = ccbm_pkg::CHR_RAM_BANKS;
        if (r_state == S_INIT) begin
            w_div_req.start    = 1'b1;
            w_div_req.dividend = ccbm_pkg::t_bank'(w_win_idx);
            if (!w_win_chr) begin
                w_div_req.divisor = eff_count(w_init_prg_cnt, ccbm_pkg::MAX_PRG_BANKS);
            end else if (w_init_chr_cnt != '0) begin
                w_div_req.divisor = eff_count(w_init_chr_cnt, ccbm_pkg::MAX_CHR_BANKS);
            end
        end else begin
            w_div_req.start = (r_state == S_EXEC) && w_is_map &&
                              (r_kind != ccbm_pkg::KIND_REINIT);
            if (r_kind == ccbm_pkg::KIND_MAP_PRG) begin
                w_div_req.divisor = w_prg_eff;
            end else if (r_kind == ccbm_pkg::KIND_MAP_CHR_ROM) begin
                w_div_req.divisor = w_chr_eff;
            end
        end
    end

    ccbm_mod_unit u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // access decode on the latched word and the memory read data
    always_comb begin
        w_res.target     = ccbm_pkg::TGT_NONE;
        w_res.ext_addr   = '0;
        w_res.read_data  = '0;
        w_res.write_data = '0;
        w_res.is_write   = 1'b0;
        unique case (r_kind) inside
            ccbm_pkg::KIND_CPU_RD: begin
                if (r_adr < ccbm_pkg::ADR_IO_LO) begin
                    w_res.target    = ccbm_pkg::TGT_RAM;
                    w_res.ext_addr  = ccbm_pkg::t_ext'(r_adr[AW-1:0]);
                    w_res.read_data = w_ram_rd;
                end else if (r_adr < ccbm_pkg::ADR_IO_END) begin
                    w_res.target   = ccbm_pkg::TGT_IO;
                    w_res.ext_addr = ccbm_pkg::t_ext'(r_adr);
                end else if (r_adr < ccbm_pkg::ADR_SRAM) begin
                    w_res.target = ccbm_pkg::TGT_NONE;
                end else if (r_adr < ccbm_pkg::ADR_PRG) begin
                    if (r_sram_en) begin
                        w_res.target   = ccbm_pkg::TGT_SRAM;
                        w_res.ext_addr = ccbm_pkg::t_ext'(r_adr[12:0]);
                    end
                end else begin
                    w_res.target   = ccbm_pkg::TGT_PRG_ROM;
                    w_res.ext_addr = {w_map_rd, r_adr[12:0]};
                end
            end
            ccbm_pkg::KIND_CPU_WR: begin
                if (r_adr < ccbm_pkg::ADR_IO_LO) begin
                    w_res.target     = ccbm_pkg::TGT_RAM;
                    w_res.ext_addr   = ccbm_pkg::t_ext'(r_adr[AW-1:0]);
                    w_res.write_data = r_dat;
                    w_res.is_write   = 1'b1;
                end else if (r_adr < ccbm_pkg::ADR_IO_END) begin
                    w_res.target     = ccbm_pkg::TGT_IO;
                    w_res.ext_addr   = ccbm_pkg::t_ext'(r_adr);
                    w_res.write_data = r_dat;
                    w_res.is_write   = 1'b1;
                end else if ((r_adr >= ccbm_pkg::ADR_SRAM) && (r_adr < ccbm_pkg::ADR_PRG) &&
                             r_sram_en) begin
                    w_res.target     = ccbm_pkg::TGT_SRAM;
                    w_res.ext_addr   = ccbm_pkg::t_ext'(r_adr[12:0]);
                    w_res.write_data = r_dat;
                    w_res.is_write   = 1'b1;
                end else if (r_mapper_en) begin
                    w_res.target     = ccbm_pkg::TGT_MAPPER;
                    w_res.ext_addr   = ccbm_pkg::t_ext'(r_adr);
                    w_res.write_data = r_dat;
                    w_res.is_write   = 1'b1;
                end
            end
            ccbm_pkg::KIND_CHR_RD, ccbm_pkg::KIND_CHR_WR: begin
                w_res.target   = r_chr_ram ? ccbm_pkg::TGT_CHR_RAM : ccbm_pkg::TGT_CHR_ROM;
                w_res.ext_addr = ccbm_pkg::t_ext'({w_map_rd, r_adr[9:0]});
                if (r_kind == ccbm_pkg::KIND_CHR_WR) begin
                    w_res.write_data = r_dat;
                    w_res.is_write   = 1'b1;
                end
            end
            default: begin
                w_res.target = ccbm_pkg::TGT_NONE;
            end
        endcase
    end

    // result word of map and reinit words
    always_comb begin
        w_map_done            = '0;
        w_map_done.target     = ccbm_pkg::TGT_MAP_DONE;
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == AW'(RAM_BYTES - 1)) begin
                    n_state = S_INIT;
                end
            end
            S_IDLE: begin
                if (w_acc) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (r_kind == ccbm_pkg::KIND_REINIT) begin
                    n_state = S_INIT;
                end else if (w_is_map) begin
                    n_state = S_DIV;
                end else if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_DIV: begin
                if (w_div_rsp.done) begin
                    n_state = S_FINISH;
                end
            end
            S_INIT: begin
                n_state = S_INIT_WAIT;
            end
            S_INIT_WAIT: begin
                if (w_div_rsp.done) begin
                    if (r_win == ccbm_pkg::LAST_WINDOW) begin
                        n_state = r_init_rsp ? S_FINISH : S_IDLE;
                    end else begin
                        n_state = S_INIT;
                    end
                end
            end
            S_FINISH: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control, configuration and output registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_win       <= '0;
            r_init_rsp  <= 1'b0;
            r_prg_cnt   <= ccbm_pkg::RST_PRG_COUNT;
            r_chr_cnt   <= ccbm_pkg::RST_CHR_COUNT;
            r_sram_en   <= 1'b1;
            r_mapper_en <= 1'b0;
            r_chr_ram   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            // configuration writes
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    ccbm_pkg::CFG_PRG_COUNT: r_prg_cnt   <= i_cfg_data;
                    ccbm_pkg::CFG_CHR_COUNT: r_chr_cnt   <= i_cfg_data;
                    ccbm_pkg::CFG_SRAM_EN:   r_sram_en   <= i_cfg_data[0];
                    ccbm_pkg::CFG_MAPPER:    r_mapper_en <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end

            // clearing sweep
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                r_win      <= '0;
                r_init_rsp <= 1'b0;
            end

            // reinit word starts a sweep over the windows
            if ((r_state == S_EXEC) && (r_kind == ccbm_pkg::KIND_REINIT)) begin
                r_win      <= '0;
                r_init_rsp <= 1'b1;
            end

            // window sweep progress
            if ((r_state == S_INIT_WAIT) && w_div_rsp.done) begin
                r_win <= r_win + 1'b1;
                if (r_win == ccbm_pkg::LAST_WINDOW) begin
                    r_chr_ram <= (w_init_chr_cnt == '0);
                end
            end

            // pattern memory select from map words
            if ((r_state == S_DIV) && w_div_rsp.done) begin
                if ((r_kind == ccbm_pkg::KIND_MAP_CHR_ROM) && w_chr_present) begin
                    r_chr_ram <= 1'b0;
                end else if (r_kind == ccbm_pkg::KIND_MAP_CHR_RAM) begin
                    r_chr_ram <= 1'b1;
                end
            end

            // output register
            if ((r_state == S_EXEC) && !w_is_map && w_out_free) begin
                r_out_valid <= 1'b1;
                r_out       <= w_res;
            end else if ((r_state == S_FINISH) && w_out_free) begin
                r_out_valid <= 1'b1;
                r_out       <= w_map_done;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // latched request word
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_kind <= i_req.kind;
            r_adr  <= i_req.address;
            r_dat  <= i_req.data;
            r_slot <= i_req.slot;
            r_bank <= i_req.bank;
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.target     = r_out.target;
    assign o_rsp.ext_addr   = r_out.ext_addr;
    assign o_rsp.read_data  = r_out.read_data;
    assign o_rsp.write_data = r_out.write_data;
    assign o_rsp.is_write   = r_out.is_write;

`ifndef ASSERT_OFF
    // an accepted word is decoded in the following cycle
    a_acc_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |=> (r_state == S_EXEC))
        else $error("accepted word not decoded next cycle");

    // the remainder unit only finishes while the sequencer waits for it
    a_div_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_rsp.done |-> ((r_state == S_DIV) || (r_state == S_INIT_WAIT)))
        else $error("remainder done outside a wait state");

    // work ram is written only by the clearing sweep or a cpu write into ram
    a_ram_we: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ram_we |-> ((r_state == S_CLEAR) ||
                      ((r_kind == ccbm_pkg::KIND_CPU_WR) && (r_adr < ccbm_pkg::ADR_IO_LO))))
        else $error("unexpected work ram write");
`endif

endmodule

`default_nettype wire
